// File: hw/rtl/ictf_pkg.sv
// Package for the IMU complementary tilt filter.
// Holds widths, register indexes, CORDIC angle table and sequencer states.
// No dependencies.
package ictf_pkg;

  localparam int TableLen       = 24;
  localparam int AngleIterDef   = 16;
  localparam int AccW           = 48;
  localparam int CordW          = 40;
  localparam int ZW             = 28;
  localparam int TiltW          = 17;
  localparam int OutW           = 24;
  localparam int CfgIdxW        = 1;
  localparam int CfgDataW       = 24;

  localparam logic [CfgIdxW-1:0] CfgGyroStep   = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBlendWeight = 1'd1;

  localparam logic [23:0] GyroStepRst    = 24'd23488;
  localparam logic [15:0] BlendWeightRst = 16'd63570;

  localparam logic signed [AccW-1:0] AccMax = 48'sd549755813887;
  localparam logic signed [AccW-1:0] AccMin = -48'sd549755813888;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ITER,
    ST_TILT,
    ST_GYRO,
    ST_MULA,
    ST_MULB,
    ST_BLEND,
    ST_OUT
  } ictf_state_t;

  // atan(2^-i) in 2^-16 degree units
  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:  atan_entry = 22'd2949120;
      5'd1:  atan_entry = 22'd1740967;
      5'd2:  atan_entry = 22'd919879;
      5'd3:  atan_entry = 22'd466945;
      5'd4:  atan_entry = 22'd234379;
      5'd5:  atan_entry = 22'd117304;
      5'd6:  atan_entry = 22'd58666;
      5'd7:  atan_entry = 22'd29335;
      5'd8:  atan_entry = 22'd14668;
      5'd9:  atan_entry = 22'd7334;
      5'd10: atan_entry = 22'd3667;
      5'd11: atan_entry = 22'd1833;
      5'd12: atan_entry = 22'd917;
      5'd13: atan_entry = 22'd458;
      5'd14: atan_entry = 22'd229;
      5'd15: atan_entry = 22'd115;
      5'd16: atan_entry = 22'd57;
      5'd17: atan_entry = 22'd29;
      5'd18: atan_entry = 22'd14;
      5'd19: atan_entry = 22'd7;
      5'd20: atan_entry = 22'd4;
      5'd21: atan_entry = 22'd2;
      5'd22: atan_entry = 22'd1;
      default: atan_entry = 22'd0;
    endcase
  endfunction

endpackage

// File: hw/rtl/imu_complementary_tilt_filter.sv
// IMU complementary tilt filter, top level.
// Depends on ictf_pkg.
//
// Usage:
//   s_axis_* carries one raw IMU sample per transfer; m_axis_* returns one
//   result per sample. cfg_* writes gyro_step (index 0) or blend_weight
//   (index 1); other indexes are ignored. Write configuration while idle.
// Timing:
//   A sample is taken only when the block is idle. Two CORDIC atan2 runs
//   share one shift/add stage, one step per cycle, each at most
//   ANGLE_ITERATIONS steps (fewer when the residual reaches zero, none when
//   the denominator is zero). Then one gyro step per axis, and a blend
//   through MULA, MULB and BLEND per tilt axis on one multiplier. The next
//   sample is taken the cycle after the result transfer; the block takes no
//   new sample before then.
// Reset:
//   rst clears the running and filter angles to zero and reloads both
//   registers with their defaults.
// Stall:
//   The result sits in the output register until m_axis_tready; the block
//   takes no new sample meanwhile.
module imu_complementary_tilt_filter #(
  parameter int ANGLE_ITERATIONS = ictf_pkg::AngleIterDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (16 bits each)
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tilt_x_accel[16:0], tilt_y_accel[33:17], rot_x_gyro[57:34],
  // rot_y_gyro[81:58], rot_z_gyro[105:82], fused_x[129:106],
  // fused_y[153:130], zero fill to 160
  output logic [159:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ictf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ictf_pkg::CfgDataW-1:0] cfg_data
);
  import ictf_pkg::*;

  localparam int IterUsed = (ANGLE_ITERATIONS < TableLen) ? ANGLE_ITERATIONS : TableLen;
  localparam logic [4:0] IterLast = 5'(IterUsed - 1);

  ictf_state_t state, state_next;

  logic [23:0] gyro_step;
  logic [15:0] blend_weight;

  logic signed [15:0] smp [6];
  logic signed [AccW-1:0] angle_acc [3];
  logic signed [AccW-1:0] blend_acc [2];
  logic signed [AccW-1:0] inc [3];

  logic signed [CordW-1:0] cx, cy;
  logic signed [ZW-1:0]    cz;
  logic [4:0]              iter;
  logic                    pass;   // 0: X tilt, 1: Y tilt
  logic [1:0]              axis;
  logic signed [TiltW-1:0] tilt [2];

  logic signed [63:0] prod;
  logic signed [63:0] sum;

  // CORDIC operand selection
  logic signed [15:0] num, den;
  always_comb begin
    num = pass ? smp[5] : smp[4];
    den = pass ? smp[3] : smp[5];
  end

  // One rotation step
  logic signed [CordW-1:0] sx, sy;
  logic signed [ZW-1:0]    tab;
  always_comb begin
    sx  = cx >>> iter;
    sy  = cy >>> iter;
    tab = ZW'(atan_entry(iter));
  end

  // Rounding and clamp of the CORDIC angle
  logic signed [ZW-1:0] zr;
  logic signed [TiltW-1:0] tz, ty_map;
  always_comb begin
    zr = (cz + ZW'(128)) >>> 8;
    if (zr > ZW'(46080))       tz = 17'sd46080;
    else if (zr < -ZW'(46080)) tz = -17'sd46080;
    else                       tz = TiltW'(zr);
    // shifted angle above -90 degrees loses 90, else gains 270
    if (tz > -17'sd23040) ty_map = tz - 17'sd23040;
    else                  ty_map = TiltW'({tz[TiltW-1], tz} + 18'sd69120);
  end

  // Saturating add for the running angles
  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] a,
                                                    input logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s > $signed({AccMax[AccW-1], AccMax}))      sat_add = AccMax;
    else if (s < $signed({AccMin[AccW-1], AccMin})) sat_add = AccMin;
    else                                            sat_add = s[AccW-1:0];
  endfunction

  // Gyro increment of the current axis
  logic signed [AccW-1:0] gprod;
  always_comb begin
    gprod = AccW'(smp[{1'b0, axis}] * signed'({1'b0, gyro_step}));
  end

  // Blend rounding and saturation
  logic signed [63:0] bsh;
  logic signed [AccW-1:0] bsat;
  always_comb begin
    bsh = (sum + 64'sd32768) >>> 16;
    if (bsh > 64'(AccMax))      bsat = AccMax;
    else if (bsh < 64'(AccMin)) bsat = AccMin;
    else                        bsat = bsh[AccW-1:0];
  end

  // Multiplier operands for the blend steps (one product per cycle)
  logic signed [48:0] ma;
  logic signed [17:0] mb;
  always_comb begin
    if (state == ST_MULA) begin
      ma = {blend_acc[axis[0]][AccW-1], blend_acc[axis[0]]} +
           {inc[axis[0]][AccW-1], inc[axis[0]]};
      mb = 18'(signed'({1'b0, blend_weight}));
    end else begin
      ma = 49'(tilt[axis[0]]) <<< 16;
      mb = 18'sd65536 - 18'(signed'({1'b0, blend_weight}));
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_PREP;
      ST_PREP: state_next = (den == 16'sd0) ? ST_TILT : ST_ITER;
      ST_ITER: if (cy == '0 || iter == IterLast) state_next = ST_TILT;
      ST_TILT: state_next = pass ? ST_GYRO : ST_PREP;
      ST_GYRO: if (axis == 2'd2) state_next = ST_MULA;
      ST_MULA: state_next = ST_MULB;
      ST_MULB: state_next = ST_BLEND;
      ST_BLEND: state_next = (axis == 2'd1) ? ST_OUT : ST_MULA;
      ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign cfg_ready     = (state == ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_step    <= GyroStepRst;
      blend_weight <= BlendWeightRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgGyroStep:    gyro_step    <= cfg_data;
        CfgBlendWeight: blend_weight <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Persistent angles
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) angle_acc[k] <= '0;
      for (int k = 0; k < 2; k++) blend_acc[k] <= '0;
    end else begin
      if (state == ST_GYRO) angle_acc[axis] <= sat_add(angle_acc[axis], gprod);
      if (state == ST_BLEND) blend_acc[axis[0]] <= bsat;
    end
  end

  // Datapath sequencing
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pass <= 1'b0;
        axis <= 2'd0;
        for (int k = 0; k < 6; k++) smp[k] <= s_axis_tdata[16*k +: 16];
      end
      ST_PREP: begin
        iter <= '0;
        if (den == 16'sd0) begin
          cz <= (num > 0) ? ZW'(5898240) : (num < 0) ? -ZW'(5898240) : '0;
        end else if (den < 0) begin
          cz <= (num >= 0) ? ZW'(11796480) : -ZW'(11796480);
          cx <= -(CordW'(den) <<< 16);
          cy <= -(CordW'(num) <<< 16);
        end else begin
          cz <= '0;
          cx <= CordW'(den) <<< 16;
          cy <= CordW'(num) <<< 16;
        end
      end
      ST_ITER: begin
        if (cy != '0) begin
          if (cy > 0) begin
            cx <= cx + sy; cy <= cy - sx; cz <= cz + tab;
          end else begin
            cx <= cx - sy; cy <= cy + sx; cz <= cz - tab;
          end
        end
        iter <= iter + 5'd1;
      end
      ST_TILT: begin
        if (pass) tilt[1] <= ty_map;
        else      tilt[0] <= tz;
        pass <= 1'b1;
      end
      ST_GYRO: begin
        inc[axis] <= gprod;
        axis <= (axis == 2'd2) ? 2'd0 : axis + 2'd1;
      end
      ST_MULA: begin
        prod <= 64'(ma * mb);
      end
      ST_MULB: begin
        sum <= prod + 64'(ma * mb);
      end
      ST_BLEND: begin
        axis <= axis + 2'd1;
      end
      default: ;
    endcase
  end

  // Result word
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[16:0]    = tilt[0];
    m_axis_tdata[33:17]   = tilt[1];
    m_axis_tdata[57:34]   = angle_acc[0][39:16];
    m_axis_tdata[81:58]   = angle_acc[1][39:16];
    m_axis_tdata[105:82]  = angle_acc[2][39:16];
    m_axis_tdata[129:106] = blend_acc[0][39:16];
    m_axis_tdata[153:130] = blend_acc[1][39:16];
  end

  // Checks
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_acc_range: assert property (@(posedge clk) disable iff (rst)
    angle_acc[0] <= AccMax && angle_acc[0] >= AccMin) else $error("angle out of range");

endmodule
